// ===== rtl/core/tkf_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table of the tilt-angle Kalman filter.
// Used by tkf_div and tilt_angle_kalman_filter; depends on nothing else.
`default_nettype none

package tkf_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ATAN_TABLE_LEN      = 24;
	localparam int ATAN_TABLE_FRAC     = 24;

	// Restoring divider sizes: numerator below 2^62, P + R below 2^28.
	localparam int DIV_DW = 62;
	localparam int DIV_VW = 28;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSET_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSET_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSET_Z       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN            = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP            = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_VARIANCE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_VARIANCE = 3'd6;

	localparam logic signed [15:0] ACCEL_OFFSET_X_RST = 16'sd524;
	localparam logic signed [15:0] ACCEL_OFFSET_Y_RST = 16'sd410;
	localparam logic signed [15:0] ACCEL_OFFSET_Z_RST = 16'sd1229;
	localparam logic [15:0] GYRO_GAIN_RST             = 16'd500;
	localparam logic [15:0] TIME_STEP_RST             = 16'd262;
	localparam logic [24:0] PROCESS_VARIANCE_RST      = 25'd4295;
	localparam logic [24:0] MEASUREMENT_VARIANCE_RST  = 25'd167772;
	localparam logic [26:0] ESTIMATE_VARIANCE_RST     = 27'd67108864;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
	} in_item_t;

	typedef struct packed {
		logic signed [24:0] tilt_angle;
		logic [26:0]        angle_variance;
	} out_item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQ_Y,
		S_SQ_Z,
		S_SQ_SUM,
		S_SQRT,
		S_CORDIC,
		S_GY1,
		S_GY2,
		S_PRED,
		S_VAR,
		S_PM_LO,
		S_PM_HI,
		S_PM_SUM,
		S_DIV1,
		S_PR_LO,
		S_PR_HI,
		S_PR_SUM,
		S_DIV2,
		S_OUT
	} state_t;

	// atan(2^-i) in degrees, Q.24.
	function automatic logic [31:0] atan_q24(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'd754974720;
			5'd1:  r = 32'd445687602;
			5'd2:  r = 32'd235489088;
			5'd3:  r = 32'd119537938;
			5'd4:  r = 32'd60000934;
			5'd5:  r = 32'd30029717;
			5'd6:  r = 32'd15018523;
			5'd7:  r = 32'd7509720;
			5'd8:  r = 32'd3754917;
			5'd9:  r = 32'd1877466;
			5'd10: r = 32'd938734;
			5'd11: r = 32'd469367;
			5'd12: r = 32'd234684;
			5'd13: r = 32'd117342;
			5'd14: r = 32'd58671;
			5'd15: r = 32'd29335;
			5'd16: r = 32'd14668;
			5'd17: r = 32'd7334;
			5'd18: r = 32'd3667;
			5'd19: r = 32'd1833;
			5'd20: r = 32'd917;
			5'd21: r = 32'd458;
			5'd22: r = 32'd229;
			5'd23: r = 32'd115;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tkf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tkf_pkg for its default sizes.
`default_nettype none

module tkf_div #(
	parameter int DW = tkf_pkg::DIV_DW,
	parameter int VW = tkf_pkg::DIV_VW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic      [DW-1:0] quotient,
	output logic               done
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          ge;

	assign trial    = {rem_q, quo_q[DW-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign quotient = quo_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tilt_angle_kalman_filter.sv =====
// Tilt-angle estimator: offset removal, CORDIC tilt, gyro prediction and a scalar Kalman update.
// Depends on tkf_pkg and tkf_div.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one raw accelerometer and gyro sample.
//   Output channel out_valid/out_ready/out_data carries the filtered angle (signed Q8.16 degrees
//   by default) and the posterior variance (Q3.24).
//   A plain write port (cfg_we, cfg_index, cfg_data) sets offsets, gains and variances;
//   write it only while the block is idle.
//   One sample is worked on at a time: in_ready is high only while the sequencer idles.
//   The time from input transfer to result is set mostly by two restoring divisions,
//   a square root and the CORDIC rotation, one step per cycle.
//   A finished result sits in an output register; a new sample is taken while it waits.
//   If the receiver stalls with a result still held, the next result waits in the
//   sequencer and the filter state is not advanced until it moves into the register.
//   Reset restores the default registers, a zero angle and a variance of 4.0.
`default_nettype none

module tilt_angle_kalman_filter #(
	parameter int ANGLE_FRAC_BITS = tkf_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = tkf_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire tkf_pkg::in_item_t                   in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output tkf_pkg::out_item_t                       out_data,
	input  wire logic                                cfg_we,
	input  wire logic [tkf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [tkf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import tkf_pkg::*;

	localparam int AW  = ANGLE_FRAC_BITS + 10;
	localparam int MSH = ATAN_TABLE_FRAC - ANGLE_FRAC_BITS;
	localparam int GSH = 32 - ANGLE_FRAC_BITS;
	localparam logic signed [32:0] HALF_M = (MSH == 0) ? 33'sd0 : (33'sd1 <<< (MSH - 1));
	localparam logic signed [51:0] HALF_G = 52'sd1 <<< (GSH - 1);
	localparam logic signed [51:0] LIM    = 52'sd180 <<< ANGLE_FRAC_BITS;
	localparam logic [4:0] CI_LAST = 5'(CORDIC_STEPS - 1);

	state_t state_q, state_d;

	logic signed [15:0] off_x_q, off_y_q, off_z_q;
	logic [15:0]        gain_q, ts_q;
	logic [24:0]        pv_q, rv_q;
	logic signed [AW-1:0] est_q;
	logic [26:0]        evar_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [16:0] ax_q, ay_q, az_q;
	logic signed [15:0] gx_q;
	logic signed [51:0] prod_q;
	logic [61:0]        acc_q;
	logic [49:0]        rad_q, res_q, bit_q;
	logic signed [27:0] cx_q, cy_q;
	logic signed [31:0] cz_q;
	logic [4:0]         ci_q;
	logic               zero_q;
	logic signed [AW-1:0] meas_q, pred_q, fin_q;
	logic [26:0]        p_q, post_q;
	logic [27:0]        sum_q;
	logic [33:0]        mag_q, corr_q;
	logic               neg_q;

	logic signed [33:0] mul_a;
	logic signed [17:0] mul_b;
	logic               div_start, div_done, out_load;
	logic [61:0]        div_num, div_quo;
	logic [34:0]        ssq;
	logic [49:0]        trial, res_nx;
	logic               sq_ge;
	logic signed [27:0] xs, ys;
	logic signed [31:0] tz;
	logic signed [32:0] mz;
	logic signed [51:0] incr_r, pred_w, fin_w;
	logic signed [AW:0] innov;

	function automatic logic signed [AW-1:0] clamp(input logic signed [51:0] v);
		logic signed [AW-1:0] r;
		if (v > LIM) r = AW'(LIM);
		else if (v < -LIM) r = AW'(-LIM);
		else r = AW'(v);
		return r;
	endfunction

	tkf_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (sum_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	// Shared datapath helpers.
	assign ssq    = 35'(acc_q[33:0]) + 35'(prod_q[33:0]);
	assign trial  = res_q + bit_q;
	assign sq_ge  = rad_q >= trial;
	assign res_nx = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
	assign xs     = cx_q >>> ci_q;
	assign ys     = cy_q >>> ci_q;
	assign tz     = signed'(atan_q24(ci_q));
	assign mz     = (33'(cz_q) + HALF_M) >>> MSH;
	assign incr_r = (prod_q + HALF_G) >>> GSH;
	assign pred_w = 52'(est_q) + incr_r;
	assign innov  = (AW + 1)'(meas_q) - (AW + 1)'(pred_q);
	assign fin_w  = neg_q ? (52'(pred_q) - signed'({18'b0, corr_q}))
	                      : (52'(pred_q) + signed'({18'b0, corr_q}));
	assign div_num = acc_q + (62'(prod_q[51:0]) << 17) + 62'(sum_q >> 1);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		in_ready  = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_SQ_Y;
			S_SQ_Y: begin
				mul_a   = 34'(ay_q);
				mul_b   = 18'(ay_q);
				state_d = S_SQ_Z;
			end
			S_SQ_Z: begin
				mul_a   = 34'(az_q);
				mul_b   = 18'(az_q);
				state_d = S_SQ_SUM;
			end
			S_SQ_SUM: state_d = S_SQRT;
			S_SQRT: if (bit_q[0]) state_d = S_CORDIC;
			S_CORDIC: if (ci_q == CI_LAST) state_d = S_GY1;
			S_GY1: begin
				mul_a   = 34'(gx_q);
				mul_b   = {2'b0, gain_q};
				state_d = S_GY2;
			end
			S_GY2: begin
				mul_a   = $signed(prod_q[33:0]);
				mul_b   = {2'b0, ts_q};
				state_d = S_PRED;
			end
			S_PRED: state_d = S_VAR;
			S_VAR: state_d = (sum_q == '0) ? S_OUT : S_PM_LO;
			S_PM_LO: begin
				mul_a   = {7'b0, p_q};
				mul_b   = {1'b0, mag_q[16:0]};
				state_d = S_PM_HI;
			end
			S_PM_HI: begin
				mul_a   = {7'b0, p_q};
				mul_b   = {1'b0, mag_q[33:17]};
				state_d = S_PM_SUM;
			end
			S_PM_SUM: begin
				div_start = 1'b1;
				state_d   = S_DIV1;
			end
			S_DIV1: if (div_done) state_d = S_PR_LO;
			S_PR_LO: begin
				mul_a   = {7'b0, p_q};
				mul_b   = {1'b0, rv_q[16:0]};
				state_d = S_PR_HI;
			end
			S_PR_HI: begin
				mul_a   = {7'b0, p_q};
				mul_b   = {10'b0, rv_q[24:17]};
				state_d = S_PR_SUM;
			end
			S_PR_SUM: begin
				div_start = 1'b1;
				state_d   = S_DIV2;
			end
			S_DIV2: if (div_done) state_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			off_x_q     <= ACCEL_OFFSET_X_RST;
			off_y_q     <= ACCEL_OFFSET_Y_RST;
			off_z_q     <= ACCEL_OFFSET_Z_RST;
			gain_q      <= GYRO_GAIN_RST;
			ts_q        <= TIME_STEP_RST;
			pv_q        <= PROCESS_VARIANCE_RST;
			rv_q        <= MEASUREMENT_VARIANCE_RST;
			est_q       <= '0;
			evar_q      <= ESTIMATE_VARIANCE_RST;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
				est_q       <= fin_q;
				evar_q      <= post_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ACCEL_OFFSET_X:       off_x_q <= cfg_data[15:0];
					REG_ACCEL_OFFSET_Y:       off_y_q <= cfg_data[15:0];
					REG_ACCEL_OFFSET_Z:       off_z_q <= cfg_data[15:0];
					REG_GYRO_GAIN:            gain_q  <= cfg_data[15:0];
					REG_TIME_STEP:            ts_q    <= cfg_data[15:0];
					REG_PROCESS_VARIANCE:     pv_q    <= cfg_data[24:0];
					REG_MEASUREMENT_VARIANCE: rv_q    <= cfg_data[24:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (out_load) begin
			out_q.tilt_angle     <= 25'(fin_q);
			out_q.angle_variance <= post_q;
		end
		unique case (state_q)
			S_IDLE: begin
				ax_q <= 17'(in_data.accel_x) - 17'(off_x_q);
				ay_q <= 17'(in_data.accel_y) - 17'(off_y_q);
				az_q <= 17'(in_data.accel_z) - 17'(off_z_q);
				gx_q <= in_data.gyro_x;
			end
			S_SQ_Z: acc_q <= 62'(prod_q[33:0]);
			S_SQ_SUM: begin
				rad_q <= 50'(ssq) << 16;
				res_q <= '0;
				bit_q <= 50'(1) << 48;
			end
			S_SQRT: begin
				if (sq_ge) rad_q <= rad_q - trial;
				res_q <= res_nx;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					cx_q   <= signed'(28'(res_nx));
					cy_q   <= 28'(ax_q) <<< 8;
					cz_q   <= '0;
					ci_q   <= '0;
					zero_q <= (res_nx == '0) && (ax_q == '0);
				end
			end
			S_CORDIC: begin
				// Rotate toward the x axis; the sign of y picks the direction.
				if (!cy_q[27]) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + tz;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - tz;
				end
				ci_q <= ci_q + 1'b1;
				if (ci_q == CI_LAST) begin
					meas_q <= '0;
				end
			end
			S_GY1: begin
				meas_q <= zero_q ? '0 : AW'(mz);
			end
			S_PRED: begin
				pred_q <= clamp(pred_w);
				p_q    <= evar_q + 27'(pv_q);
				sum_q  <= 28'(evar_q) + 28'(pv_q) + 28'(rv_q);
			end
			S_VAR: begin
				neg_q  <= innov[AW];
				mag_q  <= 34'(unsigned'(innov[AW] ? -innov : innov));
				fin_q  <= pred_q;
				post_q <= '0;
			end
			S_PM_HI: acc_q <= 62'(prod_q[51:0]);
			S_DIV1: if (div_done) corr_q <= 34'(div_quo);
			S_PR_HI: acc_q <= 62'(prod_q[51:0]);
			S_DIV2: begin
				if (div_done) begin
					post_q <= 27'(div_quo);
					fin_q  <= clamp(fin_w);
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_est_range: assert property (@(posedge clk) disable iff (!arst_n)
		(52'(est_q) <= LIM) && (52'(est_q) >= -LIM))
		else $error("angle estimate outside +-180 degrees");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider finished outside a wait state");
	a_post_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (post_q <= 27'(rv_q)))
		else $error("posterior variance exceeds measurement variance");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_load) |=> (state_q == S_OUT))
		else $error("result dropped while output register was full");
`endif

endmodule

`default_nettype wire

// ===== tb/tkf_checker.sv =====
// Scoreboard for tilt_angle_kalman_filter: tracks register writes and input transfers.
// Predicts each filtered angle and posterior variance, then compares them with the output transfers.
// Depends on tkf_pkg.
`timescale 1ns / 1ps

module tkf_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  tkf_pkg::in_item_t                in_data,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  tkf_pkg::out_item_t               out_data,
	input  logic                             cfg_we,
	input  logic [tkf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tkf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                               fail_count,
	output int                               pending,
	output logic                             xfer
);
	import tkf_pkg::*;

	localparam int FRAC  = 16;
	localparam int STEPS = 16;

	// Arctangent of 2^-i in degrees, Q.24.
	localparam longint ATAN_DEG [24] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115
	};

	longint offset_x, offset_y, offset_z;
	longint gain, dt, q_var, r_var;
	longint est_angle, est_var;
	out_item_t filtered_q[$];

	assign pending = filtered_q.size();
	assign xfer = (in_valid && in_ready) || (out_valid && out_ready);

	function automatic longint round_q(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp180(input longint a);
		longint lim;
		lim = longint'(180) << FRAC;
		if (a > lim) return lim;
		if (a < -lim) return -lim;
		return a;
	endfunction

	function automatic longint int_sqrt(input longint n);
		longint res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint accel_tilt(input longint ax, input longint ay, input longint az);
		longint x, y, z, xs, ys;
		x = int_sqrt((ay * ay + az * az) << 16);
		y = ax * 256;
		z = 0;
		if (x == 0 && y == 0) return 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += ATAN_DEG[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_DEG[i];
			end
		end
		return round_q(z, 24 - FRAC);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint ax, ay, az, meas, pred, p, total, innov, mag, corr, angle, post;
		out_item_t res;
		if (!arst_n) begin
			offset_x = 524; offset_y = 410; offset_z = 1229;
			gain = 500; dt = 262; q_var = 4295; r_var = 167772;
			est_angle = 0; est_var = 67108864;
			fail_count = 0;
			filtered_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACCEL_OFFSET_X:       offset_x = longint'(signed'(cfg_data[15:0]));
					REG_ACCEL_OFFSET_Y:       offset_y = longint'(signed'(cfg_data[15:0]));
					REG_ACCEL_OFFSET_Z:       offset_z = longint'(signed'(cfg_data[15:0]));
					REG_GYRO_GAIN:            gain = cfg_data[15:0];
					REG_TIME_STEP:            dt = cfg_data[15:0];
					REG_PROCESS_VARIANCE:     q_var = cfg_data;
					REG_MEASUREMENT_VARIANCE: r_var = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				ax = longint'(in_data.accel_x) - offset_x;
				ay = longint'(in_data.accel_y) - offset_y;
				az = longint'(in_data.accel_z) - offset_z;
				meas = accel_tilt(ax, ay, az);
				pred = clamp180(est_angle
					+ round_q(longint'(in_data.gyro_x) * gain * dt, 32 - FRAC));
				p = est_var + q_var;
				total = p + r_var;
				angle = pred;
				post = 0;
				if (total != 0) begin
					innov = meas - pred;
					mag = innov < 0 ? -innov : innov;
					corr = (p * mag + total / 2) / total;
					angle = innov < 0 ? pred - corr : pred + corr;
					post = (p * r_var + total / 2) / total;
				end
				angle = clamp180(angle);
				est_angle = angle;
				est_var = post;
				res.tilt_angle = angle[24:0];
				res.angle_variance = post[26:0];
				filtered_q.push_back(res);
			end
			if (out_valid && out_ready) begin
				if (filtered_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: unexpected result angle=%0d var=%0d",
							out_data.tilt_angle, out_data.angle_variance);
				end else begin
					res = filtered_q.pop_front();
					if (res.tilt_angle !== out_data.tilt_angle
							|| res.angle_variance !== out_data.angle_variance) begin
						fail_count++;
						if (fail_count <= 10)
							$display("ERROR: angle exp %0d got %0d, var exp %0d got %0d",
								res.tilt_angle, out_data.tilt_angle,
								res.angle_variance, out_data.angle_variance);
					end
				end
			end
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the tilt_angle_kalman_filter testbench: clock, reset, stimulus and verdict.
// Depends on tkf_pkg, tilt_angle_kalman_filter and tkf_checker.
`timescale 1ns / 1ps

module tb_top;
	import tkf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 250;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count, pending;
	logic xfer;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 0;
	int quiet_cycles = 0;
	logic signed [15:0] off_x = 524, off_y = 410, off_z = 1229;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	tilt_angle_kalman_filter u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tkf_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .xfer(xfer)
	);

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (1500) @(posedge clk);
				hold_req = 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (xfer) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_sample(input in_item_t s);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic send_accel(input int ax, input int ay, input int az, input int gx);
		in_item_t s;
		s.accel_x = 16'(ax);
		s.accel_y = 16'(ay);
		s.accel_z = 16'(az);
		s.gyro_x = 16'(gx);
		send_sample(s);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_filter();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs(input int ox, input int oy, input int oz, input int gain,
			input int dt, input int qv, input int rv);
		write_reg(REG_ACCEL_OFFSET_X, 25'(ox));
		write_reg(REG_ACCEL_OFFSET_Y, 25'(oy));
		write_reg(REG_ACCEL_OFFSET_Z, 25'(oz));
		write_reg(REG_GYRO_GAIN, 25'(gain));
		write_reg(REG_TIME_STEP, 25'(dt));
		write_reg(REG_PROCESS_VARIANCE, 25'(qv));
		write_reg(REG_MEASUREMENT_VARIANCE, 25'(rv));
		off_x = 16'(ox); off_y = 16'(oy); off_z = 16'(oz);
	endtask

	// Mostly a gravity-sized vector around the offsets, sometimes raw noise.
	task automatic send_random();
		int g;
		if ($urandom_range(99) < 70) begin
			g = $urandom_range(0, 32768) - 16384;
			send_accel(off_x + g, off_y + $urandom_range(0, 4000) - 2000,
				off_z + 16384 - (g < 0 ? -g : g) / 2 + $urandom_range(0, 2000) - 1000,
				$urandom_range(0, 4000) - 2000);
		end else begin
			send_accel($urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults: zero vector, horizontal reference zero, field extremes.
		send_accel(524, 410, 1229, 0);
		send_accel(524 + 1000, 410, 1229, 0);
		send_accel(524 - 1000, 410, 1229, 100);
		send_accel(32767, 32767, 32767, 32767);
		send_accel(-32768, -32768, -32768, -32768);
		send_accel(0, 0, 0, 0);
		send_accel(524, 410, 1229 + 16384, 0);
		send_accel(-1, -1, -1, -1);
		drain_filter();

		// Extreme offsets, largest gain and step, variances of 1.0: big gyro increments saturate.
		load_regs(-32768, -32768, -32768, 65535, 65535, 16777216, 16777216);
		send_accel(32767, 32767, 32767, 32767);
		send_accel(32767, 32767, 32767, 32767);
		send_accel(-32768, -32768, -32768, -32768);
		send_accel(-32768, -32768, -32768, -32768);
		send_accel(0, -32768, -32768, 1);
		drain_filter();

		// Zero variances: after one step P is zero and the gain falls to zero.
		load_regs(32767, 32767, 32767, 0, 0, 0, 0);
		send_accel(32767, 32767, 32767, 0);
		send_accel(0, 0, 0, 32767);
		send_accel(-32768, 32767, 32767, -32768);
		send_accel(100, 200, 300, 5);
		drain_filter();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7) load_regs(524, 410, 1229, 500, 262, 4295, 167772);
			else load_regs($urandom, $urandom, $urandom, $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 16777216),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : $urandom_range(0, 16777216));
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			if (ph == 4) hold_req = 1;
			repeat (225) send_random();
			drain_filter();
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
